@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge out of reset.
`define ALFR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies another in the same cycle.
`define ALFR_ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
// Check that a condition implies another in the next cycle.
`define ALFR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ALFR_ASSERT(lbl, clk, rst_n, prop, msg)
`define ALFR_ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg)
`define ALFR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

@@ rtl/alfr_pkg.sv @@
package alfr_pkg;

	// Generator geometry
	localparam int TABLE_LEN = 55;
	localparam int WORD_BITS = 30;
	localparam int LAG_SHORT = 24;
	localparam int TAP_POS   = (2 * TABLE_LEN - LAG_SHORT) % TABLE_LEN;
	localparam int RAW_SHIFT = 6;

	// Field widths
	localparam int SEED_BITS = 30;
	localparam int RAW_BITS  = 24;
	localparam int VAL_BITS  = 32;
	localparam int SPAN_BITS = VAL_BITS + 1;

	// Counter widths
	localparam int FILL_CNT_BITS = $clog2(TABLE_LEN + 1);
	localparam int DIV_STEPS     = RAW_BITS;
	localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

	// Opcodes
	localparam logic OP_RESEED = 1'b0;
	localparam logic OP_DRAW   = 1'b1;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_FILL,
		ST_DIVIDE,
		ST_HOLD
	} state_t;

	// Request to the remainder unit
	typedef struct packed {
		logic                 start;
		logic [RAW_BITS-1:0]  dividend;
		logic [SPAN_BITS-1:0] divisor;
	} div_req_t;

	// Answer from the remainder unit
	typedef struct packed {
		logic                busy;
		logic                done;
		logic [RAW_BITS-1:0] remainder;
	} div_rsp_t;

	// Take the raw number out of a generator sum
	function automatic logic [RAW_BITS-1:0] raw_of(input word_t sum);
		logic [63:0] ext;
		ext = 64'(sum);
		return ext[RAW_SHIFT +: RAW_BITS];
	endfunction

endpackage

@@ rtl/alfr_in_if.sv @@
interface alfr_in_if;
	logic                               valid;
	logic                               ready;
	logic                               opcode;
	logic signed [alfr_pkg::VAL_BITS-1:0] range_low;
	logic signed [alfr_pkg::VAL_BITS-1:0] range_high;

	modport source (output valid, output opcode, output range_low, output range_high,
		input ready);
	modport sink (input valid, input opcode, input range_low, input range_high,
		output ready);
endinterface

@@ rtl/alfr_out_if.sv @@
interface alfr_out_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 drew;
	logic        [alfr_pkg::RAW_BITS-1:0] raw_number;
	logic signed [alfr_pkg::VAL_BITS-1:0] ranged_value;

	modport source (output valid, output drew, output raw_number, output ranged_value,
		input ready);
	modport sink (input valid, input drew, input raw_number, input ranged_value,
		output ready);
endinterface

@@ rtl/alfr_cell.sv @@
module alfr_cell (
	input  logic            clk,
	input  logic            shift,
	input  alfr_pkg::word_t d,
	output alfr_pkg::word_t q
);

	alfr_pkg::word_t word_q;

	// Take the neighbor's word on a shift, else hold
	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

@@ rtl/alfr_rem_div.sv @@
`include "assert_macros.svh"

module alfr_rem_div (
	input  logic               clk,
	input  logic               arst_n,
	input  alfr_pkg::div_req_t req,
	output alfr_pkg::div_rsp_t rsp
);

	localparam logic [alfr_pkg::DIV_CNT_BITS-1:0] LAST_STEP =
		alfr_pkg::DIV_CNT_BITS'(alfr_pkg::DIV_STEPS - 1);

	logic                                 busy_q;
	logic                                 done_q;
	logic [alfr_pkg::DIV_CNT_BITS-1:0]    cnt_q;
	logic [alfr_pkg::RAW_BITS-1:0]        dvd_q;
	logic [alfr_pkg::RAW_BITS-1:0]        rem_q;
	logic [alfr_pkg::SPAN_BITS-1:0]       dsr_q;
	logic [alfr_pkg::RAW_BITS:0]          trial;
	logic [alfr_pkg::SPAN_BITS-1:0]       trial_ext;
	logic [alfr_pkg::RAW_BITS:0]          trial_sub;
	logic [alfr_pkg::RAW_BITS-1:0]        rem_d;

	// One restoring step: bring down a dividend bit, subtract if it fits
	always_comb begin
		trial     = {rem_q, dvd_q[alfr_pkg::RAW_BITS-1]};
		trial_ext = alfr_pkg::SPAN_BITS'(trial);
		trial_sub = trial - dsr_q[alfr_pkg::RAW_BITS:0];
		if (trial_ext >= dsr_q) begin
			rem_d = trial_sub[alfr_pkg::RAW_BITS-1:0];
		end else begin
			rem_d = trial[alfr_pkg::RAW_BITS-1:0];
		end
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift dividend, update partial remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[alfr_pkg::RAW_BITS-2:0], 1'b0};
			rem_q <= rem_d;
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

	`ALFR_ASSERT_IMPLY(a_start_idle, clk, arst_n, req.start, !busy_q, "start while busy")
	`ALFR_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q, "done held over one cycle")
	`ALFR_ASSERT_NEXT(a_last_done, clk, arst_n, busy_q && !req.start && cnt_q == LAST_STEP, done_q, "last step without done")

endmodule

@@ rtl/additive_lagged_fibonacci_rng.sv @@
// Channel  | Dir | Payload                                   | Transaction
// ---------+-----+-------------------------------------------+-------------------
// in_ch    | in  | opcode, range_low, range_high             | valid && ready
// out_ch   | out | drew, raw_number, ranged_value            | valid && ready
// cfg      | in  | cfg_wr_data (seed_value)                  | cfg_wr_en
//
// A draw runs the bit-serial remainder unit, one quotient bit per cycle. A
// reseed shifts the 55-word ring of cells, one Fibonacci word per cycle. An
// empty range skips the remainder unit. After reset the ring fills from
// seed 0 with in_ch.ready low; configuration writes are taken meanwhile.
// A result waits in the output register while the next transaction is taken.
`include "assert_macros.svh"

module additive_lagged_fibonacci_rng (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [alfr_pkg::SEED_BITS-1:0]  cfg_wr_data,
	alfr_in_if.sink                         in_ch,
	alfr_out_if.source                      out_ch
);

	localparam int LAST = alfr_pkg::TABLE_LEN - 1;
	localparam logic [alfr_pkg::FILL_CNT_BITS-1:0] FILL_LAST = alfr_pkg::FILL_CNT_BITS'(1);

	alfr_pkg::state_t                  state_q, state_d;
	logic [alfr_pkg::SEED_BITS-1:0]    seed_q;
	logic [alfr_pkg::FILL_CNT_BITS-1:0] fill_cnt_q;
	alfr_pkg::word_t                   fib_a_q, fib_b_q;
	alfr_pkg::word_t                   ring_word [alfr_pkg::TABLE_LEN];
	alfr_pkg::word_t                   sum;
	alfr_pkg::word_t                   tail;
	logic [alfr_pkg::RAW_BITS-1:0]     raw;
	logic [alfr_pkg::SPAN_BITS-1:0]    span;
	logic                              empty;
	logic                              in_fire;
	logic                              is_draw;
	logic                              draw_go;
	logic                              filling;
	logic                              ring_shift;
	logic                              out_load;
	alfr_pkg::div_req_t                div_req;
	alfr_pkg::div_rsp_t                div_rsp;
	logic [alfr_pkg::VAL_BITS-1:0]     lo_q;
	logic                              res_drew_q;
	logic [alfr_pkg::RAW_BITS-1:0]     res_raw_q;
	logic [alfr_pkg::VAL_BITS-1:0]     res_val_q;
	logic                              out_valid_q;
	logic                              out_drew_q;
	logic [alfr_pkg::RAW_BITS-1:0]     out_raw_q;
	logic [alfr_pkg::VAL_BITS-1:0]     out_val_q;

	// Ring of cells: position LAST is the write word, 0 and TAP_POS the tap words
	for (genvar i = 0; i < alfr_pkg::TABLE_LEN; i++) begin : g_ring
		if (i == LAST) begin : g_tail
			alfr_cell u_cell (.clk(clk), .shift(ring_shift), .d(tail), .q(ring_word[i]));
		end else begin : g_body
			alfr_cell u_cell (.clk(clk), .shift(ring_shift), .d(ring_word[i+1]),
				.q(ring_word[i]));
		end
	end

	alfr_rem_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Decode the incoming transaction; drive the ring, divider request and output load
	always_comb begin
		in_fire = in_ch.valid && in_ch.ready;
		is_draw = in_ch.opcode == alfr_pkg::OP_DRAW;
		span    = {in_ch.range_high[alfr_pkg::VAL_BITS-1], in_ch.range_high}
			- {in_ch.range_low[alfr_pkg::VAL_BITS-1], in_ch.range_low};
		empty   = span[alfr_pkg::SPAN_BITS-1] || (span == '0);
		draw_go = in_fire && is_draw && !empty;
		sum     = ring_word[0] + ring_word[alfr_pkg::TAP_POS];
		raw     = alfr_pkg::raw_of(sum);
		filling = (state_q == alfr_pkg::ST_INIT) || (state_q == alfr_pkg::ST_FILL);
		ring_shift = filling || draw_go;
		tail    = filling ? fib_a_q : sum;
		out_load = (state_q == alfr_pkg::ST_HOLD) && (!out_valid_q || out_ch.ready);

		div_req.start    = draw_go;
		div_req.dividend = raw;
		div_req.divisor  = span + 1'b1;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alfr_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and input ready
	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		case (state_q)
			alfr_pkg::ST_INIT: begin
				if (fill_cnt_q == FILL_LAST) begin
					state_d = alfr_pkg::ST_IDLE;
				end
			end
			alfr_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					if (!is_draw) begin
						state_d = alfr_pkg::ST_FILL;
					end else if (empty) begin
						state_d = alfr_pkg::ST_HOLD;
					end else begin
						state_d = alfr_pkg::ST_DIVIDE;
					end
				end
			end
			alfr_pkg::ST_FILL: begin
				if (fill_cnt_q == FILL_LAST) begin
					state_d = alfr_pkg::ST_HOLD;
				end
			end
			alfr_pkg::ST_DIVIDE: begin
				if (div_rsp.done) begin
					state_d = alfr_pkg::ST_HOLD;
				end
			end
			alfr_pkg::ST_HOLD: begin
				if (out_load) begin
					state_d = alfr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = alfr_pkg::ST_INIT;
			end
		endcase
	end

	// Seed register, Fibonacci feed and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q     <= '0;
			fib_a_q    <= '0;
			fib_b_q    <= alfr_pkg::WORD_BITS'(1);
			fill_cnt_q <= alfr_pkg::FILL_CNT_BITS'(alfr_pkg::TABLE_LEN);
		end else begin
			if (cfg_wr_en) begin
				seed_q <= cfg_wr_data;
			end
			if (in_fire && !is_draw) begin
				fib_a_q    <= alfr_pkg::WORD_BITS'(seed_q);
				fib_b_q    <= alfr_pkg::WORD_BITS'(1);
				fill_cnt_q <= alfr_pkg::FILL_CNT_BITS'(alfr_pkg::TABLE_LEN);
			end else if (filling) begin
				fib_a_q    <= fib_b_q;
				fib_b_q    <= fib_a_q + fib_b_q;
				fill_cnt_q <= fill_cnt_q - 1'b1;
			end
		end
	end

	// Build the pending result
	always_ff @(posedge clk) begin
		if (in_fire) begin
			lo_q       <= in_ch.range_low;
			res_drew_q <= draw_go;
			res_raw_q  <= draw_go ? raw : '0;
			res_val_q  <= is_draw ? in_ch.range_low : '0;
		end else if (div_rsp.done) begin
			res_val_q <= alfr_pkg::VAL_BITS'(div_rsp.remainder) + lo_q;
		end
	end

	// Output register: load when empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_drew_q <= res_drew_q;
			out_raw_q  <= res_raw_q;
			out_val_q  <= res_val_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.drew         = out_drew_q;
	assign out_ch.raw_number   = out_raw_q;
	assign out_ch.ranged_value = out_val_q;

	`ALFR_ASSERT_NEXT(a_fire_busy, clk, arst_n, in_fire, state_q != alfr_pkg::ST_IDLE, "idle after accept")
	`ALFR_ASSERT_IMPLY(a_nodraw_raw, clk, arst_n, out_ch.valid && !out_ch.drew, out_ch.raw_number == '0, "raw set without draw")
	`ALFR_ASSERT_IMPLY(a_fill_cnt, clk, arst_n, filling, fill_cnt_q != '0, "fill count ran out")
	`ALFR_ASSERT_IMPLY(a_div_state, clk, arst_n, div_rsp.busy, state_q == alfr_pkg::ST_DIVIDE, "divider busy outside divide")

endmodule
